>>> design/olir_pkg.sv
// Shared types and constants for the ordered list insert/remove unit.
package olir_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_GRAB,
    S_SHIFT,
    S_PUT,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic move;
    logic take;
    logic found;
    logic put;
    logic dec;
    logic publish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic pos_ok;
    logic more;
    logic hit;
    logic out_busy;
  } sts_t;

endpackage

>>> design/olir_if.sv
// Request and result channel interfaces of the ordered list unit.
interface olir_req_if;
  import olir_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [CNT_W-1:0]         position;
  logic signed [DATA_W-1:0] value_in;

  modport source (output valid, operation, position, value_in, input ready);
  modport sink   (input valid, operation, position, value_in, output ready);
endinterface

interface olir_rsp_if;
  import olir_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] value_out;
  logic signed [CNT_W-1:0]  found_index;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, ok, value_out, found_index, entry_count, input ready);
  modport sink   (input valid, ok, value_out, found_index, entry_count, output ready);
endinterface

>>> design/olir_ctrl.sv
// Controller state machine that sequences each list request.
module olir_ctrl import olir_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.pos_ok) begin
          state_nxt = S_DONE;
        end else begin
          case (sts.op)
            OP_INSERT: state_nxt = sts.more ? S_SHIFT : S_PUT;
            OP_REMOVE: state_nxt = S_FETCH;
            OP_GET:    state_nxt = S_FETCH;
            OP_LOCATE: state_nxt = S_SCAN;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_FETCH: state_nxt = S_GRAB;
      S_GRAB: begin
        state_nxt = (sts.op == OP_REMOVE && sts.more) ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        if (!sts.more) state_nxt = (sts.op == OP_INSERT) ? S_PUT : S_DONE;
      end
      S_PUT: state_nxt = S_DONE;
      S_SCAN: begin
        if (sts.hit || !sts.more) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: ;
      S_FETCH: cmd.rd = 1'b1;
      S_GRAB: begin
        cmd.take = 1'b1;
        cmd.dec  = (sts.op == OP_REMOVE) && !sts.more;
      end
      S_SHIFT: begin
        cmd.move = 1'b1;
        cmd.rd   = sts.more;
        cmd.dec  = !sts.more && (sts.op == OP_REMOVE);
      end
      S_PUT: cmd.put = 1'b1;
      S_SCAN: begin
        cmd.found = sts.hit;
        cmd.rd    = !sts.hit && sts.more;
      end
      S_DONE: cmd.publish = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

>>> design/olir_datapath.sv
// Datapath with the entry memory, count, pointer and result registers.
module olir_datapath import olir_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [1:0]               in_operation,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value_in,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic signed [CNT_W-1:0]  out_found_index,
  output logic [CNT_W-1:0]         out_entry_count
);

  logic [DATA_W-1:0] mem [CAPACITY];

  op_t                     op_r;
  logic [CNT_W-1:0]        pos_r;
  logic [DATA_W-1:0]       val_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [DATA_W-1:0]       rdata_r;
  logic [ADDR_W-1:0]       raddr_r;
  logic                    rvalid_r;
  logic                    ok_r, ok_nxt;
  logic [DATA_W-1:0]       vout_r, vout_nxt;
  logic signed [CNT_W-1:0] fidx_r, fidx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_ok_r;
  logic [DATA_W-1:0]       out_vout_r;
  logic signed [CNT_W-1:0] out_fidx_r;
  logic [CNT_W-1:0]        out_cnt_r;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [CNT_W-1:0]  loc;

  assign loc = pos_r - CNT_W'(1);

  // A shift step writes the word read in the previous cycle to its neighbor.
  always_comb begin
    wr_en   = (cmd.move && rvalid_r) || cmd.put;
    wr_data = cmd.put ? val_r : rdata_r;
    if (cmd.put) begin
      wr_addr = loc[ADDR_W-1:0];
    end else if (op_r == OP_INSERT) begin
      wr_addr = raddr_r + ADDR_W'(1);
    end else begin
      wr_addr = raddr_r - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) begin
      rdata_r <= mem[ptr_r[ADDR_W-1:0]];
      raddr_r <= ptr_r[ADDR_W-1:0];
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.hit      = rvalid_r && (rdata_r == val_r);
    sts.out_busy = out_valid_r && !out_ready;
    case (op_r)
      OP_INSERT: begin
        sts.pos_ok = (cnt_r < CNT_W'(CAPACITY)) && (pos_r != '0)
                     && (pos_r <= cnt_r + CNT_W'(1));
        sts.more   = ptr_r != (pos_r - CNT_W'(2));
      end
      OP_LOCATE: begin
        sts.pos_ok = cnt_r != '0;
        sts.more   = ptr_r < cnt_r;
      end
      default: begin
        sts.pos_ok = (pos_r != '0) && (pos_r <= cnt_r);
        sts.more   = ptr_r < cnt_r;
      end
    endcase
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load) begin
      case (op_t'(in_operation))
        OP_INSERT: ptr_nxt = cnt_r - CNT_W'(1);
        OP_LOCATE: ptr_nxt = '0;
        default:   ptr_nxt = in_position - CNT_W'(1);
      endcase
    end else if (cmd.rd) begin
      ptr_nxt = (op_r == OP_INSERT) ? ptr_r - CNT_W'(1) : ptr_r + CNT_W'(1);
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    ok_nxt   = ok_r;
    vout_nxt = vout_r;
    fidx_nxt = fidx_r;
    if (cmd.load) begin
      ok_nxt   = 1'b0;
      vout_nxt = '0;
      fidx_nxt = '1;
    end
    if (cmd.take) begin
      ok_nxt   = 1'b1;
      vout_nxt = rdata_r;
    end
    if (cmd.found) begin
      ok_nxt   = 1'b1;
      fidx_nxt = CNT_W'(raddr_r);
    end
    if (cmd.put) begin
      ok_nxt  = 1'b1;
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.dec) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rvalid_r    <= cmd.rd;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    ok_r   <= ok_nxt;
    vout_r <= vout_nxt;
    fidx_r <= fidx_nxt;
    if (cmd.load) begin
      op_r  <= op_t'(in_operation);
      pos_r <= in_position;
      val_r <= in_value_in;
    end
    if (cmd.publish) begin
      out_ok_r   <= ok_r;
      out_vout_r <= vout_r;
      out_fidx_r <= fidx_r;
      out_cnt_r  <= cnt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_value_out   = out_vout_r;
  assign out_found_index = out_fidx_r;
  assign out_entry_count = out_cnt_r;

endmodule

>>> design/ordered_list_insert_remove_unit.sv
// Top level of the ordered list unit: controller plus datapath.
//
//  Channel  Direction  Handshake     Payload
//  in_ch    sink       valid/ready   operation, position, value_in
//  out_ch   source     valid/ready   ok, value_out, found_index, entry_count
//
// One request is in work at a time, from its accepting cycle through the cycle
// that publishes its result.
// Insert, remove and locate move or compare one entry per cycle through the
// single read and single write port of the entry memory.
// Reset clears the entry count; entry contents are not cleared.
// A finished result waits in an output register, so a new request is taken
// while it stalls; the next result is held back until that one leaves.
module ordered_list_insert_remove_unit import olir_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  olir_req_if.sink   in_ch,
  olir_rsp_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  olir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  olir_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_position     (in_ch.position),
    .in_value_in     (in_ch.value_in),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ok          (out_ch.ok),
    .out_value_out   (out_ch.value_out),
    .out_found_index (out_ch.found_index),
    .out_entry_count (out_ch.entry_count)
  );

endmodule
